/* rtl/sns_pkg.sv */
// Shared types and constants of the SPI-NOR sequencer.
package sns_pkg;

  // Result actions
  localparam logic [1:0] ACT_SEND = 2'd0;
  localparam logic [1:0] ACT_CLK  = 2'd1;
  localparam logic [1:0] ACT_END  = 2'd2;
  localparam logic [1:0] ACT_DONE = 2'd3;

  // Completion status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ERASE_PARAM = 3'd1;
  localparam logic [2:0] ST_ERASE_TMO   = 3'd2;
  localparam logic [2:0] ST_WRITE_PARAM = 3'd3;
  localparam logic [2:0] ST_WRITE_TMO   = 3'd4;
  localparam logic [2:0] ST_VER_PARAM   = 3'd5;
  localparam logic [2:0] ST_MISMATCH    = 3'd6;

  // Input functions
  localparam logic [2:0] FN_ERASE  = 3'd0;
  localparam logic [2:0] FN_PROG   = 3'd1;
  localparam logic [2:0] FN_VERIFY = 3'd2;
  localparam logic [2:0] FN_UID    = 3'd3;
  localparam logic [2:0] FN_RX     = 3'd4;

  // Configuration register indexes
  localparam logic REG_WAIT_LIMIT   = 1'b0;
  localparam logic REG_RESUME_TWICE = 1'b1;

  // Flash opcodes
  localparam logic [7:0] OP_RESUME = 8'hFF;
  localparam logic [7:0] OP_WREN   = 8'h06;
  localparam logic [7:0] OP_PROG   = 8'h02;
  localparam logic [7:0] OP_FREAD  = 8'h0B;
  localparam logic [7:0] OP_UID    = 8'h4B;
  localparam logic [7:0] OP_RDSR   = 8'h05;

  // Slots of a job, emitted in ascending order
  localparam int SL_END0 = 0;
  localparam int SL_FF1  = 1;
  localparam int SL_FF2  = 2;
  localparam int SL_OEND = 3;
  localparam int SL_WREN = 4;
  localparam int SL_WEND = 5;
  localparam int SL_OPC  = 6;
  localparam int SL_A0   = 7;
  localparam int SL_A1   = 8;
  localparam int SL_A2   = 9;
  localparam int SL_A3   = 10;
  localparam int SL_A4   = 11;
  localparam int SL_D0   = 12;
  localparam int SL_D1   = 13;
  localparam int SL_D2   = 14;
  localparam int SL_D3   = 15;
  localparam int SL_END1 = 16;
  localparam int SL_POLL = 17;
  localparam int SL_PCLK = 18;
  localparam int SL_CLK  = 19;
  localparam int SL_DONE = 20;
  localparam int NSLOT   = 21;
  localparam int SLOT_W  = 5;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic [NSLOT-1:0] mask;
    logic [7:0]       opcode;
    logic [23:0]      addr;
    logic [31:0]      data;
    logic [2:0]       status;
    logic [63:0]      uid;
  } job_t;

endpackage

/* rtl/sns_front.sv */
// Front part: accepts items, tracks the operation state and builds result jobs.
module sns_front #(
  parameter int ERASE_BLOCK = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         func,
  input  logic [31:0]        address,
  input  logic [31:0]        byte_length,
  input  logic [31:0]        data_word,
  input  logic               last_word,
  input  logic [7:0]         rx_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_data,
  output logic               push,
  output sns_pkg::job_t      push_job,
  input  logic               q_full
);
  import sns_pkg::*;

  localparam logic [2:0] M_IDLE       = 3'd0;
  localparam logic [2:0] M_ERASE_POLL = 3'd1;
  localparam logic [2:0] M_WRITE_POLL = 3'd2;
  localparam logic [2:0] M_WRITE_RUN  = 3'd3;
  localparam logic [2:0] M_VERIFY_RX  = 3'd4;
  localparam logic [2:0] M_VERIFY_RUN = 3'd5;
  localparam logic [2:0] M_UID_RX     = 3'd6;

  localparam logic [31:0] EB_MASK = 32'(ERASE_BLOCK - 1);
  localparam logic [31:0] EB_SIZE = 32'(ERASE_BLOCK);
  localparam logic [7:0]  ERASE_OP = (ERASE_BLOCK == 256) ? 8'h81 : 8'h20;

  logic [23:0] wait_limit_r;
  logic        resume_twice_r;
  logic [2:0]  mode_r, mode_nxt;
  logic [31:0] cur_r, cur_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [23:0] poll_r, poll_nxt;
  logic [4:0]  bc_r, bc_nxt;
  logic [31:0] rword_r, rword_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic [63:0] uid_r, uid_nxt;
  logic        run_r, run_nxt;
  logic        err_r, err_nxt;

  job_t        job;
  logic        accept;
  logic [32:0] erase_sum;
  logic        do_wtail, wcmd, do_vtail;
  logic [31:0] wbase, wnext, cur_step, rem_step, rword_new;
  logic [63:0] uid_new;
  logic [4:0]  bc_inc;
  logic [2:0]  uid_idx;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign push      = accept && (job.mask != '0);
  assign push_job  = job;

  assign erase_sum = {1'b0, address} + {1'b0, byte_length};
  assign wnext     = wbase + 32'd4;
  assign cur_step  = cur_r + EB_SIZE;
  assign rem_step  = rem_r - EB_SIZE;
  assign bc_inc    = bc_r + 5'd1;
  assign rword_new = rword_r | ({24'd0, rx_byte} << {bc_r[1:0], 3'd0});
  assign uid_idx   = ~bc_r[2:0];
  assign uid_new   = uid_r ^ ({56'd0, rx_byte} << {uid_idx, 3'd0});

  // Work out the next state and the job of the accepted item
  always_comb begin
    mode_nxt  = mode_r;
    cur_nxt   = cur_r;
    rem_nxt   = rem_r;
    poll_nxt  = poll_r;
    bc_nxt    = bc_r;
    rword_nxt = rword_r;
    exp_nxt   = exp_r;
    uid_nxt   = uid_r;
    run_nxt   = run_r;
    err_nxt   = err_r;
    job       = '0;
    do_wtail  = 1'b0;
    wcmd      = 1'b0;
    do_vtail  = 1'b0;
    wbase     = cur_r;
    case (mode_r)
      M_IDLE: begin
        case (func)
          FN_ERASE: begin
            if (byte_length == '0 || ((address | byte_length) & EB_MASK) != '0 ||
                erase_sum[32]) begin
              job.mask[SL_DONE] = 1'b1;
              job.status = ST_ERASE_PARAM;
            end else begin
              cur_nxt  = address;
              rem_nxt  = byte_length;
              mode_nxt = M_ERASE_POLL;
              job.mask[SL_FF1] = 1'b1;
              job.mask[SL_FF2] = resume_twice_r;
              job.mask[SL_OEND] = 1'b1;
              job.mask[SL_WREN] = 1'b1;
              job.mask[SL_WEND] = 1'b1;
              job.mask[SL_OPC] = 1'b1;
              job.mask[SL_A0] = 1'b1;
              job.mask[SL_A1] = 1'b1;
              job.mask[SL_A2] = 1'b1;
              job.opcode = ERASE_OP;
              job.addr = address[23:0];
              job.mask[SL_END1] = 1'b1;
              if (wait_limit_r != '0) begin
                job.mask[SL_POLL] = 1'b1;
                job.mask[SL_PCLK] = 1'b1;
                poll_nxt = 24'd1;
                bc_nxt = '0;
              end else begin
                job.mask[SL_DONE] = 1'b1;
                job.status = ST_ERASE_TMO;
                mode_nxt = M_IDLE;
              end
            end
          end
          FN_PROG: begin
            if (address[1:0] != 2'd0) begin
              if (last_word) begin
                job.mask[SL_DONE] = 1'b1;
                job.status = ST_WRITE_PARAM;
              end else begin
                mode_nxt = M_WRITE_RUN;
                err_nxt = 1'b1;
                rem_nxt = {29'd0, ST_WRITE_PARAM};
              end
            end else begin
              job.mask[SL_FF1] = 1'b1;
              job.mask[SL_FF2] = resume_twice_r;
              job.mask[SL_OEND] = 1'b1;
              wbase = address;
              wcmd = 1'b1;
              do_wtail = 1'b1;
            end
          end
          FN_VERIFY: begin
            if (address[1:0] != 2'd0) begin
              if (last_word) begin
                job.mask[SL_DONE] = 1'b1;
                job.status = ST_VER_PARAM;
              end else begin
                mode_nxt = M_VERIFY_RUN;
                err_nxt = 1'b1;
                rem_nxt = {29'd0, ST_VER_PARAM};
              end
            end else begin
              cur_nxt = address;
              job.mask[SL_FF1] = 1'b1;
              job.mask[SL_FF2] = resume_twice_r;
              job.mask[SL_OEND] = 1'b1;
              job.mask[SL_OPC] = 1'b1;
              job.mask[SL_A0] = 1'b1;
              job.mask[SL_A1] = 1'b1;
              job.mask[SL_A2] = 1'b1;
              job.mask[SL_A3] = 1'b1;
              job.mask[SL_A4] = 1'b1;
              job.opcode = OP_FREAD;
              job.addr = address[23:0];
              do_vtail = 1'b1;
            end
          end
          FN_UID: begin
            job.mask[SL_FF1] = 1'b1;
            job.mask[SL_FF2] = resume_twice_r;
            job.mask[SL_OEND] = 1'b1;
            job.mask[SL_OPC] = 1'b1;
            job.mask[SL_A0] = 1'b1;
            job.mask[SL_A1] = 1'b1;
            job.mask[SL_A2] = 1'b1;
            job.mask[SL_A3] = 1'b1;
            job.mask[SL_A4] = 1'b1;
            job.opcode = OP_UID;
            job.mask[SL_CLK] = 1'b1;
            uid_nxt = '0;
            bc_nxt = '0;
            mode_nxt = M_UID_RX;
          end
          default: begin
          end
        endcase
      end
      M_ERASE_POLL, M_WRITE_POLL: begin
        if (func == FN_RX) begin
          if (bc_r == '0) begin
            bc_nxt = 5'd1;
            job.mask[SL_CLK] = 1'b1;
          end else begin
            job.mask[SL_END0] = 1'b1;
            if (rx_byte[0] && poll_r < wait_limit_r) begin
              // still busy: poll again
              poll_nxt = poll_r + 24'd1;
              bc_nxt = '0;
              job.mask[SL_POLL] = 1'b1;
              job.mask[SL_PCLK] = 1'b1;
            end else if (mode_r == M_ERASE_POLL) begin
              if (rx_byte[0]) begin
                job.mask[SL_DONE] = 1'b1;
                job.status = ST_ERASE_TMO;
                mode_nxt = M_IDLE; run_nxt = 1'b0; err_nxt = 1'b0; bc_nxt = '0;
              end else begin
                cur_nxt = cur_step;
                rem_nxt = rem_step;
                if (rem_step == '0) begin
                  job.mask[SL_DONE] = 1'b1;
                  job.status = ST_OK;
                  mode_nxt = M_IDLE; run_nxt = 1'b0; err_nxt = 1'b0; bc_nxt = '0;
                end else begin
                  job.mask[SL_WREN] = 1'b1;
                  job.mask[SL_WEND] = 1'b1;
                  job.mask[SL_OPC] = 1'b1;
                  job.mask[SL_A0] = 1'b1;
                  job.mask[SL_A1] = 1'b1;
                  job.mask[SL_A2] = 1'b1;
                  job.opcode = ERASE_OP;
                  job.addr = cur_step[23:0];
                  job.mask[SL_END1] = 1'b1;
                  if (wait_limit_r != '0) begin
                    job.mask[SL_POLL] = 1'b1;
                    job.mask[SL_PCLK] = 1'b1;
                    poll_nxt = 24'd1;
                    bc_nxt = '0;
                  end else begin
                    job.mask[SL_DONE] = 1'b1;
                    job.status = ST_ERASE_TMO;
                    mode_nxt = M_IDLE; run_nxt = 1'b0; err_nxt = 1'b0; bc_nxt = '0;
                  end
                end
              end
            end else begin
              // write wait over
              if (!run_r) begin
                job.mask[SL_DONE] = 1'b1;
                job.status = rx_byte[0] ? ST_WRITE_TMO : ST_OK;
                mode_nxt = M_IDLE; run_nxt = 1'b0; err_nxt = 1'b0; bc_nxt = '0;
              end else if (!rx_byte[0]) begin
                mode_nxt = M_WRITE_RUN;
                bc_nxt = 5'd1;
              end else begin
                mode_nxt = M_WRITE_RUN;
                err_nxt = 1'b1;
                rem_nxt = {29'd0, ST_WRITE_TMO};
              end
            end
          end
        end
      end
      M_WRITE_RUN: begin
        if (func == FN_PROG) begin
          if (err_r) begin
            if (last_word) begin
              job.mask[SL_DONE] = 1'b1;
              job.status = rem_r[2:0];
              mode_nxt = M_IDLE; run_nxt = 1'b0; err_nxt = 1'b0; bc_nxt = '0;
            end
          end else if (cur_r == '0) begin
            if (last_word) begin
              job.mask[SL_DONE] = 1'b1;
              job.status = ST_WRITE_PARAM;
              mode_nxt = M_IDLE; run_nxt = 1'b0; err_nxt = 1'b0; bc_nxt = '0;
            end else begin
              err_nxt = 1'b1;
              rem_nxt = {29'd0, ST_WRITE_PARAM};
            end
          end else begin
            wcmd = (bc_r != '0);
            do_wtail = 1'b1;
          end
        end
      end
      M_VERIFY_RX: begin
        if (func == FN_RX) begin
          rword_nxt = rword_new;
          if (bc_inc < 5'd4) begin
            bc_nxt = bc_inc;
            job.mask[SL_CLK] = 1'b1;
          end else begin
            bc_nxt = '0;
            cur_nxt = cur_r + 32'd4;
            if (rword_new != exp_r) begin
              job.mask[SL_END0] = 1'b1;
              if (!run_r) begin
                job.mask[SL_DONE] = 1'b1;
                job.status = ST_MISMATCH;
                mode_nxt = M_IDLE; run_nxt = 1'b0; err_nxt = 1'b0;
              end else begin
                mode_nxt = M_VERIFY_RUN;
                err_nxt = 1'b1;
                rem_nxt = {29'd0, ST_MISMATCH};
              end
            end else if (!run_r) begin
              job.mask[SL_END0] = 1'b1;
              job.mask[SL_DONE] = 1'b1;
              job.status = ST_OK;
              mode_nxt = M_IDLE; run_nxt = 1'b0; err_nxt = 1'b0;
            end else begin
              mode_nxt = M_VERIFY_RUN;
            end
          end
        end
      end
      M_VERIFY_RUN: begin
        if (func == FN_VERIFY) begin
          if (err_r) begin
            if (last_word) begin
              job.mask[SL_DONE] = 1'b1;
              job.status = rem_r[2:0];
              mode_nxt = M_IDLE; run_nxt = 1'b0; err_nxt = 1'b0; bc_nxt = '0;
            end
          end else if (cur_r == '0) begin
            job.mask[SL_END0] = 1'b1;
            if (last_word) begin
              job.mask[SL_DONE] = 1'b1;
              job.status = ST_VER_PARAM;
              mode_nxt = M_IDLE; run_nxt = 1'b0; err_nxt = 1'b0; bc_nxt = '0;
            end else begin
              err_nxt = 1'b1;
              rem_nxt = {29'd0, ST_VER_PARAM};
            end
          end else begin
            do_vtail = 1'b1;
          end
        end
      end
      M_UID_RX: begin
        if (func == FN_RX) begin
          uid_nxt = uid_new;
          if (bc_inc < 5'd16) begin
            bc_nxt = bc_inc;
            job.mask[SL_CLK] = 1'b1;
          end else begin
            job.mask[SL_END0] = 1'b1;
            job.mask[SL_DONE] = 1'b1;
            job.status = ST_OK;
            job.uid = uid_new;
            mode_nxt = M_IDLE; run_nxt = 1'b0; err_nxt = 1'b0; bc_nxt = '0;
          end
        end
      end
      default: begin
        mode_nxt = M_IDLE;
        run_nxt = 1'b0;
        err_nxt = 1'b0;
        bc_nxt = '0;
      end
    endcase

    // Send one program word after the page program command if needed, then end the page and wait as needed
    if (do_wtail) begin
      if (wcmd) begin
        job.mask[SL_WREN] = 1'b1;
        job.mask[SL_WEND] = 1'b1;
        job.mask[SL_OPC] = 1'b1;
        job.mask[SL_A0] = 1'b1;
        job.mask[SL_A1] = 1'b1;
        job.mask[SL_A2] = 1'b1;
        job.opcode = OP_PROG;
        job.addr = wbase[23:0];
      end
      job.mask[SL_D0] = 1'b1;
      job.mask[SL_D1] = 1'b1;
      job.mask[SL_D2] = 1'b1;
      job.mask[SL_D3] = 1'b1;
      job.data = data_word;
      cur_nxt = wnext;
      run_nxt = !last_word;
      bc_nxt = '0;
      if (!last_word && wnext[7:0] != 8'd0) begin
        mode_nxt = M_WRITE_RUN;
      end else begin
        mode_nxt = M_WRITE_POLL;
        job.mask[SL_END1] = 1'b1;
        if (wait_limit_r != '0) begin
          job.mask[SL_POLL] = 1'b1;
          job.mask[SL_PCLK] = 1'b1;
          poll_nxt = 24'd1;
        end else if (last_word) begin
          job.mask[SL_DONE] = 1'b1;
          job.status = ST_WRITE_TMO;
          mode_nxt = M_IDLE; run_nxt = 1'b0; err_nxt = 1'b0;
        end else begin
          mode_nxt = M_WRITE_RUN;
          err_nxt = 1'b1;
          rem_nxt = {29'd0, ST_WRITE_TMO};
        end
      end
    end

    // Start reading one verify word
    if (do_vtail) begin
      exp_nxt = data_word;
      rword_nxt = '0;
      bc_nxt = '0;
      run_nxt = !last_word;
      mode_nxt = M_VERIFY_RX;
      job.mask[SL_CLK] = 1'b1;
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_limit_r   <= 24'd160000;
      resume_twice_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WAIT_LIMIT:   wait_limit_r <= cfg_data;
        REG_RESUME_TWICE: resume_twice_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Advance the operation state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      cur_r   <= '0;
      rem_r   <= '0;
      poll_r  <= '0;
      bc_r    <= '0;
      rword_r <= '0;
      exp_r   <= '0;
      uid_r   <= '0;
      run_r   <= 1'b0;
      err_r   <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      cur_r   <= cur_nxt;
      rem_r   <= rem_nxt;
      poll_r  <= poll_nxt;
      bc_r    <= bc_nxt;
      rword_r <= rword_nxt;
      exp_r   <= exp_nxt;
      uid_r   <= uid_nxt;
      run_r   <= run_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

/* rtl/sns_queue.sv */
// Short job queue between the front and back parts.
module sns_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sns_pkg::job_t push_job,
  input  logic          pop,
  output sns_pkg::job_t head_job,
  output logic          empty,
  output logic          full
);
  import sns_pkg::*;

  job_t                mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_r, rd_r;
  logic [QPTR_W:0]     cnt_r;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign head_job = mem_r[rd_r];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/sns_back.sv */
// Back part: expands each job into SPI actions, one result item per cycle unless stalled.
module sns_back (
  input  logic          clk,
  input  logic          rst_n,
  input  sns_pkg::job_t head_job,
  input  logic          empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    action,
  output logic [7:0]    tx_byte,
  output logic [2:0]    status_code,
  output logic [63:0]   uid_value,
  output logic          last_result
);
  import sns_pkg::*;

  job_t               job_r;
  logic [NSLOT-1:0]   mask_r, mask_nxt;
  logic               adv, have;
  logic [SLOT_W-1:0]  slot;
  logic               valid_r;
  logic [1:0]         act_r, act_c;
  logic [7:0]         tx_r, tx_c;
  logic [2:0]         st_r, st_c;
  logic [63:0]        uid_r, uid_c;
  logic               last_r;

  assign adv      = !valid_r || out_ready;
  assign have     = (mask_r != '0);
  assign mask_nxt = mask_r & (mask_r - 1'b1);
  assign pop      = !empty && (!have || (adv && mask_nxt == '0));

  assign out_valid   = valid_r;
  assign action      = act_r;
  assign tx_byte     = tx_r;
  assign status_code = st_r;
  assign uid_value   = uid_r;
  assign last_result = last_r;

  // Find the lowest pending slot
  always_comb begin
    slot = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (mask_r[i]) slot = SLOT_W'(i);
    end
  end

  // Decode a slot into its action
  always_comb begin
    act_c = ACT_SEND;
    tx_c  = '0;
    st_c  = ST_OK;
    uid_c = '0;
    case (slot)
      SLOT_W'(SL_END0), SLOT_W'(SL_OEND), SLOT_W'(SL_WEND), SLOT_W'(SL_END1):
        act_c = ACT_END;
      SLOT_W'(SL_FF1), SLOT_W'(SL_FF2): tx_c = OP_RESUME;
      SLOT_W'(SL_WREN): tx_c = OP_WREN;
      SLOT_W'(SL_OPC):  tx_c = job_r.opcode;
      SLOT_W'(SL_A0):   tx_c = job_r.addr[23:16];
      SLOT_W'(SL_A1):   tx_c = job_r.addr[15:8];
      SLOT_W'(SL_A2):   tx_c = job_r.addr[7:0];
      SLOT_W'(SL_A3), SLOT_W'(SL_A4): tx_c = '0;
      SLOT_W'(SL_D0):   tx_c = job_r.data[7:0];
      SLOT_W'(SL_D1):   tx_c = job_r.data[15:8];
      SLOT_W'(SL_D2):   tx_c = job_r.data[23:16];
      SLOT_W'(SL_D3):   tx_c = job_r.data[31:24];
      SLOT_W'(SL_POLL): tx_c = OP_RDSR;
      SLOT_W'(SL_PCLK), SLOT_W'(SL_CLK): act_c = ACT_CLK;
      SLOT_W'(SL_DONE): begin
        act_c = ACT_DONE;
        st_c  = job_r.status;
        uid_c = job_r.uid;
      end
      default: act_c = ACT_SEND;
    endcase
  end

  // Hold the current job and load the next one as it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (pop) begin
      mask_r <= head_job.mask;
    end else if (adv && have) begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head_job;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= have;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && have) begin
      act_r  <= act_c;
      tx_r   <= tx_c;
      st_r   <= st_c;
      uid_r  <= uid_c;
      last_r <= (mask_nxt == '0);
    end
  end

endmodule

/* rtl/spi_nor_flash_sequencer.sv */
// Top level of the SPI-NOR program/erase sequencer.
// Turns erase, program, verify and unique-ID requests into byte-level SPI
// actions (send byte, clock a byte in, end transaction, done). Bytes clocked
// in from the flash come back on the input channel as func 4 items. The front
// part takes one input item per cycle while its four-entry job queue has room;
// the back part drives one result item per cycle while out_tready allows it, and
// the output register lets a finished result wait while the next item is accepted.
// Configuration writes are taken at any time and are meant to be made while the
// block is idle.
module spi_nor_flash_sequencer #(
  parameter int ERASE_BLOCK = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [2:0]   in_tuser,   // func
  input  logic [103:0] in_tdata,   // address, byte_length, data_word, rx_byte
  input  logic         in_tlast,   // last_word
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,  // action
  output logic [79:0]  out_tdata,  // tx_byte, status_code, uid_value, zero fill
  output logic         out_tlast,  // last_result
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [23:0]  cfg_data
);
  import sns_pkg::*;

  logic        push, pop, q_empty, q_full;
  job_t        push_job, head_job;
  logic [7:0]  tx_byte;
  logic [2:0]  status_code;
  logic [63:0] uid_value;

  sns_front #(.ERASE_BLOCK(ERASE_BLOCK)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .func        (in_tuser),
    .address     (in_tdata[31:0]),
    .byte_length (in_tdata[63:32]),
    .data_word   (in_tdata[95:64]),
    .last_word   (in_tlast),
    .rx_byte     (in_tdata[103:96]),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .push_job    (push_job),
    .q_full      (q_full)
  );

  sns_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  sns_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_job    (head_job),
    .empty       (q_empty),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .action      (out_tuser),
    .tx_byte     (tx_byte),
    .status_code (status_code),
    .uid_value   (uid_value),
    .last_result (out_tlast)
  );

  assign out_tdata = {5'd0, uid_value, status_code, tx_byte};

endmodule
